/* src/afdp_pkg.sv */
// ----------------------------------------------------------------------------
// afdp_pkg
// Shared types and constants of the audio format descriptor parser.
// ----------------------------------------------------------------------------
package afdp_pkg;

  // rates kept per format descriptor, also the width of the rate count
  localparam int RATE_CNT_W = 4;
  localparam logic [RATE_CNT_W-1:0] MAX_RATES = 4'd8;

  localparam logic [23:0] RATE_48K          = 24'd48000;
  localparam logic [7:0]  TYPE_IFACE        = 8'h04;
  localparam logic [7:0]  TYPE_CS_IFACE     = 8'h24;
  localparam logic [7:0]  SUBTYPE_FORMAT    = 8'h02;
  localparam logic [7:0]  FORMAT_TYPE_I     = 8'h01;
  localparam logic [7:0]  MIN_LENGTH        = 8'd2;
  localparam logic [7:0]  FORMAT_MIN_LENGTH = 8'd11;

  // register word index on the configuration port
  localparam logic REG_TARGET_IFACE = 1'b0;

  typedef struct packed {
    logic                  found;
    logic [7:0]            alt_setting;
    logic [7:0]            channels;
    logic [7:0]            subframe_bytes;
    logic [7:0]            bit_resolution;
    logic [RATE_CNT_W-1:0] rate_count;
    logic [23:0]           chosen_rate;
  } result_t;

  typedef struct packed {
    logic answered;
    logic at_start;
  } parse_status_t;

endpackage

/* src/afdp_cfg.sv */
// ----------------------------------------------------------------------------
// afdp_cfg
// Configuration register file: holds the target interface number.
// ----------------------------------------------------------------------------
module afdp_cfg
  import afdp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  target_iface
);

  logic [7:0] target_r;
  logic [7:0] target_nxt;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & (paddr[2] == REG_TARGET_IFACE);

  always_comb begin
    target_nxt = target_r;
    if (wr_en) begin
      target_nxt = pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= 8'd0;
    end else begin
      target_r <= target_nxt;
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_TARGET_IFACE) begin
      prdata = {24'd0, target_r};
    end
  end

  assign target_iface = target_r;

endmodule

/* src/afdp_parser.sv */
// ----------------------------------------------------------------------------
// afdp_parser
// Per-byte descriptor walker: tracks interface/alt setting, captures the
// first matching format type I descriptor and forms the result.
// ----------------------------------------------------------------------------
module afdp_parser
  import afdp_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          byte_accept,
  input  logic [7:0]    desc_byte,
  input  logic          last_byte,
  input  logic [7:0]    target_iface,
  output logic          res_valid,
  output result_t       res,
  output parse_status_t status
);

  typedef enum logic [1:0] {
    PH_LO  = 2'd0,
    PH_MID = 2'd1,
    PH_HI  = 2'd2
  } phase_t;

  logic [7:0]            idx_r, idx_nxt;
  logic [7:0]            length_r, length_nxt;
  logic [7:0]            type_r, type_nxt;
  logic [7:0]            subtype_r, subtype_nxt;
  logic [7:0]            iface_r, iface_nxt;
  logic [7:0]            alt_r, alt_nxt;
  logic [7:0]            kind_r, kind_nxt;
  logic [7:0]            chans_r, chans_nxt;
  logic [7:0]            subf_r, subf_nxt;
  logic [7:0]            bits_r, bits_nxt;
  logic [7:0]            rtc_r, rtc_nxt;
  logic [15:0]           accum_r, accum_nxt;
  phase_t                phase_r, phase_nxt;
  logic [RATE_CNT_W-1:0] entry_r, entry_nxt;
  logic [RATE_CNT_W-1:0] seen_r, seen_nxt;
  logic [23:0]           first_r, first_nxt;
  logic                  saw48_r, saw48_nxt;
  logic                  answered_r, answered_nxt;
  logic [23:0]           rate_val;
  logic                  desc_end;
  logic                  match;

  assign rate_val = {desc_byte, accum_r};
  assign desc_end = ({1'b0, idx_r} + 9'd1) >= {1'b0, length_r};

  always_comb begin
    idx_nxt      = idx_r;
    length_nxt   = length_r;
    type_nxt     = type_r;
    subtype_nxt  = subtype_r;
    iface_nxt    = iface_r;
    alt_nxt      = alt_r;
    kind_nxt     = kind_r;
    chans_nxt    = chans_r;
    subf_nxt     = subf_r;
    bits_nxt     = bits_r;
    rtc_nxt      = rtc_r;
    accum_nxt    = accum_r;
    phase_nxt    = phase_r;
    entry_nxt    = entry_r;
    seen_nxt     = seen_r;
    first_nxt    = first_r;
    saw48_nxt    = saw48_r;
    answered_nxt = answered_r;
    res_valid    = 1'b0;
    res          = '0;
    match        = 1'b0;

    if (byte_accept && !answered_r) begin
      if (idx_r == 8'd0) begin
        if (desc_byte < MIN_LENGTH) begin
          res_valid    = 1'b1;
          answered_nxt = 1'b1;
        end else begin
          length_nxt  = desc_byte;
          type_nxt    = 8'd0;
          subtype_nxt = 8'd0;
          kind_nxt    = 8'd0;
          rtc_nxt     = 8'd0;
          accum_nxt   = 16'd0;
          phase_nxt   = PH_LO;
          entry_nxt   = '0;
          seen_nxt    = '0;
          first_nxt   = 24'd0;
          saw48_nxt   = 1'b0;
          idx_nxt     = 8'd1;
        end
      end else begin
        case (idx_r)
          8'd1: type_nxt = desc_byte;
          8'd2: begin
            subtype_nxt = desc_byte;
            if (type_r == TYPE_IFACE) begin
              iface_nxt = desc_byte;
            end
          end
          8'd3: begin
            kind_nxt = desc_byte;
            if (type_r == TYPE_IFACE) begin
              alt_nxt = desc_byte;
            end
          end
          8'd4: chans_nxt = desc_byte;
          8'd5: subf_nxt  = desc_byte;
          8'd6: bits_nxt  = desc_byte;
          8'd7: rtc_nxt   = desc_byte;
          default: begin
            // 3-byte little-endian rate entries from byte 8 on
            case (phase_r)
              PH_LO: begin
                accum_nxt = {8'd0, desc_byte};
                phase_nxt = PH_MID;
              end
              PH_MID: begin
                accum_nxt = {desc_byte, accum_r[7:0]};
                phase_nxt = PH_HI;
              end
              default: begin
                phase_nxt = PH_LO;
                if (entry_r < MAX_RATES && {{(8-RATE_CNT_W){1'b0}}, entry_r} < rtc_r) begin
                  if (entry_r == '0) begin
                    first_nxt = rate_val;
                  end
                  if (rate_val == RATE_48K) begin
                    saw48_nxt = 1'b1;
                  end
                  seen_nxt = entry_r + 1'b1;
                end
                // saturate once past the kept entries
                if (entry_r != MAX_RATES) begin
                  entry_nxt = entry_r + 1'b1;
                end
              end
            endcase
          end
        endcase

        if (desc_end) begin
          idx_nxt = 8'd0;
          match = (iface_nxt == target_iface) && (alt_nxt != 8'd0) &&
                  (type_nxt == TYPE_CS_IFACE) && (subtype_nxt == SUBTYPE_FORMAT) &&
                  (length_r >= FORMAT_MIN_LENGTH) && (kind_nxt == FORMAT_TYPE_I);
          if (match) begin
            res_valid          = 1'b1;
            answered_nxt       = 1'b1;
            res.found          = 1'b1;
            res.alt_setting    = alt_nxt;
            res.channels       = chans_nxt;
            res.subframe_bytes = subf_nxt;
            res.bit_resolution = bits_nxt;
            if (rtc_nxt == 8'd0) begin
              // continuous range
              res.rate_count  = {{(RATE_CNT_W-1){1'b0}}, 1'b1};
              res.chosen_rate = RATE_48K;
            end else begin
              res.rate_count  = seen_nxt;
              res.chosen_rate = saw48_nxt ? RATE_48K : first_nxt;
            end
          end
        end else begin
          idx_nxt = idx_r + 8'd1;
        end
      end

      if (last_byte) begin
        res_valid = 1'b1;
      end
    end

    // rearm after the final byte of the buffer
    if (byte_accept && last_byte) begin
      idx_nxt      = 8'd0;
      length_nxt   = 8'd0;
      type_nxt     = 8'd0;
      subtype_nxt  = 8'd0;
      iface_nxt    = 8'd255;
      alt_nxt      = 8'd255;
      kind_nxt     = 8'd0;
      chans_nxt    = 8'd0;
      subf_nxt     = 8'd0;
      bits_nxt     = 8'd0;
      rtc_nxt      = 8'd0;
      accum_nxt    = 16'd0;
      phase_nxt    = PH_LO;
      entry_nxt    = '0;
      seen_nxt     = '0;
      first_nxt    = 24'd0;
      saw48_nxt    = 1'b0;
      answered_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= 8'd0;
      length_r   <= 8'd0;
      type_r     <= 8'd0;
      subtype_r  <= 8'd0;
      iface_r    <= 8'd255;
      alt_r      <= 8'd255;
      kind_r     <= 8'd0;
      chans_r    <= 8'd0;
      subf_r     <= 8'd0;
      bits_r     <= 8'd0;
      rtc_r      <= 8'd0;
      accum_r    <= 16'd0;
      phase_r    <= PH_LO;
      entry_r    <= '0;
      seen_r     <= '0;
      first_r    <= 24'd0;
      saw48_r    <= 1'b0;
      answered_r <= 1'b0;
    end else begin
      idx_r      <= idx_nxt;
      length_r   <= length_nxt;
      type_r     <= type_nxt;
      subtype_r  <= subtype_nxt;
      iface_r    <= iface_nxt;
      alt_r      <= alt_nxt;
      kind_r     <= kind_nxt;
      chans_r    <= chans_nxt;
      subf_r     <= subf_nxt;
      bits_r     <= bits_nxt;
      rtc_r      <= rtc_nxt;
      accum_r    <= accum_nxt;
      phase_r    <= phase_nxt;
      entry_r    <= entry_nxt;
      seen_r     <= seen_nxt;
      first_r    <= first_nxt;
      saw48_r    <= saw48_nxt;
      answered_r <= answered_nxt;
    end
  end

  assign status.answered = answered_r;
  assign status.at_start = (idx_r == 8'd0);

endmodule

/* src/afdp_out_buf.sv */
// ----------------------------------------------------------------------------
// afdp_out_buf
// Two-entry result buffer; keeps the byte input open while a result waits.
// ----------------------------------------------------------------------------
module afdp_out_buf
  import afdp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    space,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  result_t    mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       pop;

  assign out_valid = (count_r != 2'd0);
  assign space     = (count_r != 2'd2);
  assign pop       = out_valid & out_ready;
  assign out_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* src/audio_format_descriptor_parser.sv */
// ----------------------------------------------------------------------------
// audio_format_descriptor_parser
// Finds the format type I descriptor of one audio streaming interface in a
// configuration descriptor stream and reports its format and sample rate.
// ----------------------------------------------------------------------------
// One descriptor byte is taken per clock as long as in_ready is high. Each
// buffer (closed by in_last_byte) yields exactly one result transaction: a
// found result on the final byte of the first matching descriptor, or a
// not-found result (all fields zero) on a bad length byte or on the last
// byte. Each result is registered in the output buffer before it shows on out_*;
// a two-entry output buffer lets bytes keep flowing while a result waits, and
// in_ready drops only when both entries are held. target_interface sits at
// byte address 0 of the register port and should be written between buffers.
module audio_format_descriptor_parser
  import afdp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_desc_byte,
  input  logic                  in_last_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_found,
  output logic [7:0]            out_alt_setting,
  output logic [7:0]            out_channels,
  output logic [7:0]            out_subframe_bytes,
  output logic [7:0]            out_bit_resolution,
  output logic [RATE_CNT_W-1:0] out_rate_count,
  output logic [23:0]           out_chosen_rate
);

  logic          byte_accept;
  logic [7:0]    target_iface;
  logic          res_valid;
  result_t       res;
  result_t       out_data;
  parse_status_t status;

  assign byte_accept = in_valid & in_ready;

  afdp_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .target_iface (target_iface)
  );

  afdp_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_accept  (byte_accept),
    .desc_byte    (in_desc_byte),
    .last_byte    (in_last_byte),
    .target_iface (target_iface),
    .res_valid    (res_valid),
    .res          (res),
    .status       (status)
  );

  afdp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_found          = out_data.found;
  assign out_alt_setting    = out_data.alt_setting;
  assign out_channels       = out_data.channels;
  assign out_subframe_bytes = out_data.subframe_bytes;
  assign out_bit_resolution = out_data.bit_resolution;
  assign out_rate_count     = out_data.rate_count;
  assign out_chosen_rate    = out_data.chosen_rate;

  // a result only ever comes from an accepted byte
  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> byte_accept)
    else $error("result produced without an accepted byte");

  // the last byte of a buffer always rearms the parser
  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_accept && in_last_byte) |=> (status.at_start && !status.answered))
    else $error("parser not rearmed after last byte");

  // a found result always carries an alt setting and at least one rate
  a_found_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_alt_setting != 8'd0 && out_rate_count != '0))
    else $error("found result with empty alt setting or rate count");

  // a not-found result is all zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_alt_setting == 8'd0 && out_chosen_rate == 24'd0 &&
                                   out_rate_count == '0 && out_channels == 8'd0))
    else $error("not-found result carries data");

endmodule

/* tb/sv/tb_audio_format_descriptor_parser.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_audio_format_descriptor_parser
// Streams configuration descriptor buffers into the parser byte by byte. A
// built-in descriptor tracker predicts the one format report each buffer
// yields, and every report is checked field by field. A directed walk comes
// first, then random buffers built from interface, format and other
// descriptors, under several target interface settings.
// ----------------------------------------------------------------------------
module tb_audio_format_descriptor_parser;
  import afdp_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_BYTES  = 850;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_AT       = 8;
  localparam int HOLD_CYCLES   = 300;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       typed;
    logic       emits;
    result_t    rep;
  } walk_row_t;

  localparam result_t MISS = '0;
  localparam result_t CONT_HIT = '{found: 1'b1, alt_setting: 8'd1, channels: 8'hFF,
                                   subframe_bytes: 8'd4, bit_resolution: 8'd32,
                                   rate_count: 4'd1, chosen_rate: RATE_48K};

  localparam walk_row_t WALK [25] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, MISS},     // zero length byte opens the buffer
    '{8'h5A, 1'b0, 1'b1, 1'b0, MISS},     // ignored once answered
    '{8'hA5, 1'b1, 1'b1, 1'b0, MISS},
    '{8'h01, 1'b1, 1'b1, 1'b1, MISS},
    '{8'hFF, 1'b1, 1'b1, 1'b1, MISS},     // descriptor cut off by end of buffer
    '{8'h04, 1'b0, 1'b1, 1'b0, MISS},     // short interface descriptor: iface 0, alt 1
    '{TYPE_IFACE, 1'b0, 1'b1, 1'b0, MISS},
    '{8'h00, 1'b0, 1'b1, 1'b0, MISS},
    '{8'h01, 1'b0, 1'b1, 1'b0, MISS},
    '{8'h0B, 1'b0, 1'b1, 1'b0, MISS},     // format descriptor, continuous range
    '{TYPE_CS_IFACE, 1'b0, 1'b1, 1'b0, MISS},
    '{SUBTYPE_FORMAT, 1'b0, 1'b1, 1'b0, MISS},
    '{FORMAT_TYPE_I, 1'b0, 1'b1, 1'b0, MISS},
    '{8'hFF, 1'b0, 1'b1, 1'b0, MISS},
    '{8'h04, 1'b0, 1'b1, 1'b0, MISS},
    '{8'h20, 1'b0, 1'b1, 1'b0, MISS},
    '{8'h00, 1'b0, 1'b1, 1'b0, MISS},
    '{8'h44, 1'b0, 1'b1, 1'b0, MISS},
    '{8'hAC, 1'b0, 1'b1, 1'b0, MISS},
    '{8'h00, 1'b0, 1'b1, 1'b1, CONT_HIT},
    '{8'h00, 1'b1, 1'b1, 1'b0, MISS},     // last byte after the report: silent
    '{8'h02, 1'b0, 1'b0, 1'b0, MISS},
    '{8'hFF, 1'b0, 1'b0, 1'b0, MISS},
    '{8'h03, 1'b0, 1'b0, 1'b0, MISS},
    '{8'h80, 1'b1, 1'b0, 1'b0, MISS}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [2:0]            paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_desc_byte = '0;
  logic                  in_last_byte = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_found;
  logic [7:0]            out_alt_setting;
  logic [7:0]            out_channels;
  logic [7:0]            out_subframe_bytes;
  logic [7:0]            out_bit_resolution;
  logic [RATE_CNT_W-1:0] out_rate_count;
  logic [23:0]           out_chosen_rate;

  // tracker copy of the register and the parse state
  logic [7:0]            tgt_iface = 8'd0;
  logic [7:0]            byte_pos, desc_len, desc_kind, desc_sub;
  logic [7:0]            cur_iface, cur_alt, fmt_tag;
  logic [7:0]            fmt_ch, fmt_sub, fmt_bits, rate_field;
  logic [23:0]           rate_acc, rate_first;
  logic [RATE_CNT_W-1:0] rates_kept;
  logic                  has_48k, answered;

  result_t               format_reports_due[$];
  logic [7:0]            stream_q[$];
  result_t               want_rep;
  logic                  calm = 1'b0;
  int                    results_seen = 0;
  int                    hold_left = 0;
  logic                  hold_done = 1'b0;
  int                    fail_count = 0;
  int unsigned           cycle_count = 0;

  audio_format_descriptor_parser DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_desc_byte       (in_desc_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_found          (out_found),
    .out_alt_setting    (out_alt_setting),
    .out_channels       (out_channels),
    .out_subframe_bytes (out_subframe_bytes),
    .out_bit_resolution (out_bit_resolution),
    .out_rate_count     (out_rate_count),
    .out_chosen_rate    (out_chosen_rate)
  );

  always #4 clk = ~clk;

  function automatic void clear_parse();
    byte_pos = '0; desc_len = '0; desc_kind = '0; desc_sub = '0;
    cur_iface = 8'hFF; cur_alt = 8'hFF; fmt_tag = '0;
    fmt_ch = '0; fmt_sub = '0; fmt_bits = '0; rate_field = '0;
    rate_acc = '0; rate_first = '0; rates_kept = '0;
    has_48k = 1'b0; answered = 1'b0;
  endfunction

  // advances the tracker by one byte; returns 1 when the byte yields a report
  function automatic bit track_descriptor_byte(input logic [7:0] b, input logic last,
                                               output result_t rep);
    bit          hit;
    int          idx;
    int          off;
    logic [23:0] v;
    hit = 1'b0;
    rep = '0;
    if (!answered) begin
      idx = byte_pos;
      if (idx == 0) begin
        if (b < MIN_LENGTH) begin
          hit = 1'b1;
          answered = 1'b1;
        end else begin
          desc_len = b;
          desc_kind = '0; desc_sub = '0; fmt_tag = '0; rate_field = '0;
          rate_acc = '0; rates_kept = '0; rate_first = '0; has_48k = 1'b0;
          byte_pos = 8'd1;
        end
      end else begin
        case (idx)
          1: desc_kind = b;
          2: begin
            desc_sub = b;
            if (desc_kind == TYPE_IFACE) cur_iface = b;
          end
          3: begin
            fmt_tag = b;
            if (desc_kind == TYPE_IFACE) cur_alt = b;
          end
          4: fmt_ch = b;
          5: fmt_sub = b;
          6: fmt_bits = b;
          7: rate_field = b;
          default: begin
            // rate entries are 3-byte little-endian from byte 8 on
            off = idx - 8;
            case (off % 3)
              0: rate_acc = {16'd0, b};
              1: rate_acc = rate_acc | {8'd0, b, 8'd0};
              default: begin
                v = rate_acc | {b, 16'd0};
                rate_acc = v;
                if (off / 3 < MAX_RATES && off / 3 < rate_field) begin
                  if (off / 3 == 0) rate_first = v;
                  if (v == RATE_48K) has_48k = 1'b1;
                  rates_kept = RATE_CNT_W'(off / 3 + 1);
                end
              end
            endcase
          end
        endcase
        if (idx + 1 >= desc_len) begin
          byte_pos = '0;
          if (cur_iface == tgt_iface && cur_alt > 0 && desc_kind == TYPE_CS_IFACE &&
              desc_sub == SUBTYPE_FORMAT && desc_len >= FORMAT_MIN_LENGTH &&
              fmt_tag == FORMAT_TYPE_I) begin
            hit = 1'b1;
            answered = 1'b1;
            rep.found = 1'b1;
            rep.alt_setting = cur_alt;
            rep.channels = fmt_ch;
            rep.subframe_bytes = fmt_sub;
            rep.bit_resolution = fmt_bits;
            if (rate_field == 0) begin
              rep.rate_count = RATE_CNT_W'(1);
              rep.chosen_rate = RATE_48K;
            end else begin
              rep.rate_count = rates_kept;
              rep.chosen_rate = has_48k ? RATE_48K : rate_first;
            end
          end
        end else begin
          byte_pos = 8'(idx + 1);
        end
      end
      if (last) hit = 1'b1;
    end
    if (last) clear_parse();
    return hit;
  endfunction

  function automatic int field_diff(input string name, input int unsigned want,
                                    input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic write_target_iface(input logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_TARGET_IFACE, 2'b00};
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tgt_iface = value;
  endtask

  // one byte transaction; a typed row overrides the tracker's report
  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input logic typed_emits, input result_t typed_rep);
    result_t rep;
    bit      emits;
    if (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_desc_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    emits = track_descriptor_byte(b, last, rep);
    if (typed) begin
      emits = typed_emits;
      rep = typed_rep;
    end
    if (emits) format_reports_due.push_back(rep);
  endtask

  task automatic drain_reports();
    in_valid <= 1'b0;
    while (format_reports_due.size() != 0) @(posedge clk);
    // a silent last byte may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly well-formed buffers of interface and format descriptors, some noise
  task automatic compose_buffer();
    logic [7:0]  body[$];
    int          pick;
    int          len;
    int          n_rates;
    logic [23:0] rate;
    stream_q.delete();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 12)) stream_q.push_back(8'($urandom));
      return;
    end
    repeat ($urandom_range(1, 3)) begin
      body.delete();
      pick = $urandom_range(99);
      if (pick < 30) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(2, 4) : 9;
        body.push_back(TYPE_IFACE);
        body.push_back(($urandom_range(3) != 0) ? tgt_iface : 8'($urandom));
        case ($urandom_range(3))
          0: body.push_back(8'd0);
          1: body.push_back(8'd1);
          2: body.push_back(8'd2);
          default: body.push_back(8'($urandom));
        endcase
      end else if (pick < 80) begin
        n_rates = ($urandom_range(9) == 0) ? $urandom_range(7, 11) : $urandom_range(0, 6);
        len = 8 + 3 * n_rates;
        case ($urandom_range(9))
          0: len = len + $urandom_range(1, 2);   // partial rate entry
          1: len = $urandom_range(2, 12);
          default: ;
        endcase
        body.push_back(($urandom_range(19) != 0) ? TYPE_CS_IFACE : 8'($urandom));
        body.push_back(($urandom_range(9) != 0) ? SUBTYPE_FORMAT : 8'($urandom));
        body.push_back(($urandom_range(9) != 0) ? FORMAT_TYPE_I : 8'($urandom));
        repeat (3) body.push_back(8'($urandom));
        case ($urandom_range(5))
          0: body.push_back(8'd0);
          1: body.push_back(8'($urandom));
          2: body.push_back(8'(n_rates + 1));
          default: body.push_back(8'(n_rates));
        endcase
        // one entry more than the length allows
        repeat (n_rates + 1) begin
          rate = ($urandom_range(3) == 0) ? RATE_48K : 24'($urandom);
          body.push_back(rate[7:0]);
          body.push_back(rate[15:8]);
          body.push_back(rate[23:16]);
        end
      end else if (pick < 96) begin
        len = ($urandom_range(19) == 0) ? 255 : $urandom_range(2, 10);
        body.push_back(($urandom_range(3) == 0) ? TYPE_CS_IFACE : 8'($urandom));
      end else begin
        len = 0;
        stream_q.push_back(8'($urandom_range(1)));
      end
      if (len != 0) begin
        stream_q.push_back(8'(len));
        for (int i = 0; i < len - 1; i++)
          stream_q.push_back((i < body.size()) ? body[i] : 8'($urandom));
      end
    end
    if ($urandom_range(9) == 0 && stream_q.size() > 1)
      repeat ($urandom_range(1, stream_q.size() - 1)) void'(stream_q.pop_back());
  endtask

  // result side: random back-pressure plus one long hold-off
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen == HOLD_AT) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 15);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (format_reports_due.size() == 0) begin
        $error("result transaction with no report pending");
        fail_count++;
      end else begin
        want_rep = format_reports_due.pop_front();
        fail_count += field_diff("found", want_rep.found, out_found)
                    + field_diff("alt_setting", want_rep.alt_setting, out_alt_setting)
                    + field_diff("channels", want_rep.channels, out_channels)
                    + field_diff("subframe_bytes", want_rep.subframe_bytes, out_subframe_bytes)
                    + field_diff("bit_resolution", want_rep.bit_resolution, out_bit_resolution)
                    + field_diff("rate_count", want_rep.rate_count, out_rate_count)
                    + field_diff("chosen_rate", want_rep.chosen_rate, out_chosen_rate);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    int         phase_bytes;
    int         phase_buffers;
    logic [7:0] next_target;
    clear_parse();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    write_target_iface(8'd0);
    foreach (WALK[i])
      send_byte(WALK[i].b, WALK[i].last, WALK[i].typed, WALK[i].emits, WALK[i].rep);
    drain_reports();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: next_target = 8'hFF;   // matches the interface left over from reset
        1: next_target = 8'h00;
        2: next_target = 8'($urandom_range(1, 254));
        default: next_target = 8'h01;
      endcase
      write_target_iface(next_target);
      calm <= (phase == 1);
      phase_bytes = 0;
      phase_buffers = 0;
      while (phase_bytes < RANDOM_BYTES / 4 || phase_buffers < 10) begin
        compose_buffer();
        foreach (stream_q[k])
          send_byte(stream_q[k], k == stream_q.size() - 1, 1'b0, 1'b0, MISS);
        phase_bytes += stream_q.size();
        phase_buffers++;
      end
      drain_reports();
    end

    repeat (16) @(posedge clk);
    if (fail_count == 0 && format_reports_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
